// ===== sv/rbst_pkg.sv =====
// Shared types and constants for the ray versus box slab test unit.
`default_nettype none
package rbst_pkg;

    localparam int OUT_WIDTH = 32;
    localparam int QUO_BITS  = OUT_WIDTH - 1;

    localparam logic signed [OUT_WIDTH-1:0] T_NEG_INF = {1'b1, {(OUT_WIDTH-1){1'b0}}};
    localparam logic signed [OUT_WIDTH-1:0] T_POS_INF = {1'b0, {(OUT_WIDTH-1){1'b1}}};

    typedef enum logic [2:0] {
        RSN_HIT      = 3'd0,
        RSN_BAD_BOX  = 3'd1,
        RSN_BAD_RAY  = 3'd2,
        RSN_PAR_OUT  = 3'd3,
        RSN_DISJOINT = 3'd4,
        RSN_BEHIND   = 3'd5
    } reason_t;

    typedef struct packed {
        logic       bad_box;
        logic       bad_ray;
        logic [2:0] par;
        logic [2:0] par_out;
    } flags_t;

endpackage
`default_nettype wire

// ===== sv/rbst_div.sv =====
// Pipelined signed fixed-point slab distance divider with saturation.
`default_nettype none
module rbst_div #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                                    aclk,
    input  wire logic                                    en,
    input  wire logic signed [COORD_WIDTH:0]             diff,
    input  wire logic signed [FRAC_BITS+1:0]             dir,
    output logic signed [rbst_pkg::OUT_WIDTH-1:0]        q
);
    localparam int CW   = COORD_WIDTH;
    localparam int DW   = FRAC_BITS + 2;
    localparam int OW   = rbst_pkg::OUT_WIDTH;
    localparam int QB   = rbst_pkg::QUO_BITS;
    localparam int NW   = CW + 1 + FRAC_BITS;
    localparam int NX   = (NW > QB) ? NW : QB + 1;
    localparam int CMPW = NX + DW;

    logic [CW:0]    mag;
    logic [DW-1:0]  dmag;
    logic [NX-1:0]  a_n_reg;
    logic [DW-1:0]  a_d_reg;
    logic           a_neg_reg;

    logic [DW-1:0]  r_reg   [QB+1];
    logic [QB-1:0]  q_reg   [QB+1];
    logic [QB-1:0]  nlo_reg [QB+1];
    logic [DW-1:0]  d_reg   [QB+1];
    logic           neg_reg [QB+1];
    logic           ovf_reg [QB+1];

    logic signed [OW-1:0] q_out_reg;
    logic signed [OW-1:0] q_out_next;

    assign mag  = diff[CW] ? (-diff) : diff;
    assign dmag = dir[DW-1] ? (-dir) : dir;

    always_ff @(posedge aclk) begin
        if (en) begin
            a_n_reg   <= NX'(mag) << FRAC_BITS;
            a_d_reg   <= dmag;
            a_neg_reg <= diff[CW] ^ dir[DW-1];
            r_reg[0]   <= DW'({{DW{1'b0}}, a_n_reg[NX-1:QB]});
            q_reg[0]   <= '0;
            nlo_reg[0] <= a_n_reg[QB-1:0];
            d_reg[0]   <= a_d_reg;
            neg_reg[0] <= a_neg_reg;
            ovf_reg[0] <= (CMPW'(a_n_reg) >= (CMPW'(a_d_reg) << QB));
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [DW:0] ext;
        logic        ge;
        logic [DW:0] sub;
        assign ext = {r_reg[k], nlo_reg[k][QB-1-k]};
        assign ge  = ext >= {1'b0, d_reg[k]};
        assign sub = ext - {1'b0, d_reg[k]};
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k+1]   <= ge ? sub[DW-1:0] : ext[DW-1:0];
                q_reg[k+1]   <= {q_reg[k][QB-2:0], ge};
                nlo_reg[k+1] <= nlo_reg[k];
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    always_comb begin
        if (ovf_reg[QB]) begin
            q_out_next = neg_reg[QB] ? rbst_pkg::T_NEG_INF : rbst_pkg::T_POS_INF;
        end else if (neg_reg[QB]) begin
            q_out_next = -$signed({1'b0, q_reg[QB]});
        end else begin
            q_out_next = $signed({1'b0, q_reg[QB]});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_out_reg <= q_out_next;
        end
    end

    assign q = q_out_reg;

endmodule
`default_nettype wire

// ===== sv/ray_box_slab_test_unit.sv =====
// Top level of the ray versus axis-aligned box slab test unit.
// One ray and box request enters per clock and one result leaves per clock while
// the result side does not stall. The six slab divisions are restoring dividers
// with one quotient bit per pipeline stage, and that divider chain sets the depth.
// A stall on the result side holds the whole pipeline in place.
`default_nettype none
module ray_box_slab_test_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    localparam int DIR_WIDTH  = FRAC_BITS + 2,
    localparam int IN_BYTES   = (9 * COORD_WIDTH + 3 * DIR_WIDTH + 7) / 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [15:0]           cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z
    input  wire logic [IN_BYTES*8-1:0] s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // t_enter, t_exit
    output logic [63:0]                m_tdata,
    // hit, reason
    output logic [3:0]                 m_tuser
);
    localparam int CW      = COORD_WIDTH;
    localparam int DW      = DIR_WIDTH;
    localparam int OW      = rbst_pkg::OUT_WIDTH;
    localparam int DIV_LAT = rbst_pkg::QUO_BITS + 3;
    localparam int TW      = (DW > 16) ? DW : 16;

    logic [15:0] thr_reg;
    logic        adv;

    logic                 v0_reg;
    logic signed [CW-1:0] org_reg [3];
    logic signed [DW-1:0] dir_reg [3];
    logic signed [CW-1:0] lo_reg  [3];
    logic signed [CW-1:0] hi_reg  [3];

    logic signed [CW:0]   diff_lo [3];
    logic signed [CW:0]   diff_hi [3];
    logic [DW-1:0]        dmag    [3];
    rbst_pkg::flags_t     fl0;

    logic signed [OW-1:0] q_lo [3];
    logic signed [OW-1:0] q_hi [3];

    logic             vd_reg  [DIV_LAT];
    rbst_pkg::flags_t fld_reg [DIV_LAT];

    logic                 vn_reg;
    rbst_pkg::flags_t     fln_reg;
    logic signed [OW-1:0] nr_reg [3];
    logic signed [OW-1:0] fr_reg [3];

    logic                 vp_reg;
    rbst_pkg::flags_t     flp_reg;
    logic signed [OW-1:0] tmin_reg [3];
    logic signed [OW-1:0] tmax_reg [3];
    logic signed [OW-1:0] tmin_next [3];
    logic signed [OW-1:0] tmax_next [3];

    rbst_pkg::reason_t    reason_next;
    logic                 m_tvalid_reg;
    logic                 hit_reg;
    rbst_pkg::reason_t    reason_reg;
    logic signed [OW-1:0] te_reg;
    logic signed [OW-1:0] tx_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int a = 0; a < 3; a++) begin
                org_reg[a] <= s_tdata[a*CW +: CW];
                dir_reg[a] <= s_tdata[3*CW + a*DW +: DW];
                lo_reg[a]  <= s_tdata[3*CW + 3*DW + a*CW +: CW];
                hi_reg[a]  <= s_tdata[6*CW + 3*DW + a*CW +: CW];
            end
        end
    end

    always_comb begin
        fl0 = '0;
        for (int a = 0; a < 3; a++) begin
            diff_lo[a] = {lo_reg[a][CW-1], lo_reg[a]} - {org_reg[a][CW-1], org_reg[a]};
            diff_hi[a] = {hi_reg[a][CW-1], hi_reg[a]} - {org_reg[a][CW-1], org_reg[a]};
            dmag[a]    = dir_reg[a][DW-1] ? (-dir_reg[a]) : dir_reg[a];
            fl0.par[a]     = TW'(dmag[a]) <= TW'(thr_reg);
            fl0.par_out[a] = (org_reg[a] < lo_reg[a]) || (org_reg[a] > hi_reg[a]);
            if (lo_reg[a] > hi_reg[a]) begin
                fl0.bad_box = 1'b1;
            end
        end
        fl0.bad_ray = (dir_reg[0] == '0) && (dir_reg[1] == '0) && (dir_reg[2] == '0);
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        rbst_div #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_div_lo (
            .aclk (aclk),
            .en   (adv),
            .diff (diff_lo[a]),
            .dir  (dir_reg[a]),
            .q    (q_lo[a])
        );
        rbst_div #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_div_hi (
            .aclk (aclk),
            .en   (adv),
            .diff (diff_hi[a]),
            .dir  (dir_reg[a]),
            .q    (q_hi[a])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                vd_reg[i] <= 1'b0;
            end
            vn_reg       <= 1'b0;
            vp_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vd_reg[0] <= v0_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                vd_reg[i] <= vd_reg[i-1];
            end
            vn_reg       <= vd_reg[DIV_LAT-1];
            vp_reg       <= vn_reg;
            m_tvalid_reg <= vp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fld_reg[0] <= fl0;
            for (int i = 1; i < DIV_LAT; i++) begin
                fld_reg[i] <= fld_reg[i-1];
            end
            fln_reg <= fld_reg[DIV_LAT-1];
            for (int a = 0; a < 3; a++) begin
                if (fld_reg[DIV_LAT-1].par[a]) begin
                    nr_reg[a] <= rbst_pkg::T_NEG_INF;
                    fr_reg[a] <= rbst_pkg::T_POS_INF;
                end else if (q_lo[a] > q_hi[a]) begin
                    nr_reg[a] <= q_hi[a];
                    fr_reg[a] <= q_lo[a];
                end else begin
                    nr_reg[a] <= q_lo[a];
                    fr_reg[a] <= q_hi[a];
                end
            end
            flp_reg <= fln_reg;
            for (int a = 0; a < 3; a++) begin
                tmin_reg[a] <= tmin_next[a];
                tmax_reg[a] <= tmax_next[a];
            end
        end
    end

    always_comb begin
        tmin_next[0] = nr_reg[0];
        tmax_next[0] = fr_reg[0];
        for (int a = 1; a < 3; a++) begin
            tmin_next[a] = (nr_reg[a] > tmin_next[a-1]) ? nr_reg[a] : tmin_next[a-1];
            tmax_next[a] = (fr_reg[a] < tmax_next[a-1]) ? fr_reg[a] : tmax_next[a-1];
        end
    end

    always_comb begin
        logic done;
        done        = 1'b0;
        reason_next = rbst_pkg::RSN_HIT;
        for (int a = 0; a < 3; a++) begin
            if (!done) begin
                if (flp_reg.par[a]) begin
                    if (flp_reg.par_out[a]) begin
                        reason_next = rbst_pkg::RSN_PAR_OUT;
                        done        = 1'b1;
                    end
                end else if (tmin_reg[a] > tmax_reg[a]) begin
                    reason_next = rbst_pkg::RSN_DISJOINT;
                    done        = 1'b1;
                end
            end
        end
        if (!done && (tmax_reg[2] < 0)) begin
            reason_next = rbst_pkg::RSN_BEHIND;
        end
        if (flp_reg.bad_box) begin
            reason_next = rbst_pkg::RSN_BAD_BOX;
        end else if (flp_reg.bad_ray) begin
            reason_next = rbst_pkg::RSN_BAD_RAY;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            reason_reg <= reason_next;
            hit_reg    <= (reason_next == rbst_pkg::RSN_HIT);
            te_reg     <= (reason_next == rbst_pkg::RSN_HIT) ? tmin_reg[2] : '0;
            tx_reg     <= (reason_next == rbst_pkg::RSN_HIT) ? tmax_reg[2] : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {tx_reg, te_reg};
    assign m_tuser  = {reason_reg, hit_reg};

    a_hit_code : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] == (m_tuser[3:1] == rbst_pkg::RSN_HIT)))
        else $error("hit flag disagrees with reason code");

    a_miss_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("miss carries nonzero distances");

    a_hit_order : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> ((te_reg <= tx_reg) && !tx_reg[OW-1]))
        else $error("hit with entry after exit or exit behind origin");

    a_stall_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule
`default_nettype wire

// ===== test/ray_box_slab_test_unit_test.sv =====
// Testbench for the ray versus axis-aligned box slab test unit.
`timescale 1ns / 1ps
`default_nettype none
module ray_box_slab_test_unit_test;

    localparam int IN_BITS = (9 * 32 + 3 * 18 + 7) / 8 * 8;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic signed [31:0] org [3];
        logic signed [17:0] dir [3];
        logic signed [31:0] lo [3];
        logic signed [31:0] hi [3];
    } ray_box_t;

    typedef struct {
        logic               hit;
        rbst_pkg::reason_t  reason;
        logic signed [31:0] t_enter;
        logic signed [31:0] t_exit;
    } slab_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_BITS-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [3:0] m_tuser;

    int errors = 0;
    int idle_pct = 19;
    int quiet_cycles = 0;
    logic [15:0] threshold = '0;

    ray_box_slab_test_unit dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #10 aclk = ~aclk;

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic longint clamp_distance(input longint v);
        if (v > longint'(rbst_pkg::T_POS_INF)) return longint'(rbst_pkg::T_POS_INF);
        if (v < longint'(rbst_pkg::T_NEG_INF)) return longint'(rbst_pkg::T_NEG_INF);
        return v;
    endfunction

    function automatic slab_result_t clip_ray(input ray_box_t r, input logic [15:0] thr);
        slab_result_t res;
        longint t_near, t_far, n, f, d, mag, tmp;
        rbst_pkg::reason_t why;
        why = rbst_pkg::RSN_HIT;
        t_near = longint'(rbst_pkg::T_NEG_INF);
        t_far = longint'(rbst_pkg::T_POS_INF);
        if (r.lo[0] > r.hi[0] || r.lo[1] > r.hi[1] || r.lo[2] > r.hi[2]) begin
            why = rbst_pkg::RSN_BAD_BOX;
        end else if (r.dir[0] == 0 && r.dir[1] == 0 && r.dir[2] == 0) begin
            why = rbst_pkg::RSN_BAD_RAY;
        end else begin
            for (int a = 0; a < 3; a++) begin
                d = longint'(r.dir[a]);
                mag = d < 0 ? -d : d;
                if (mag <= longint'(thr)) begin
                    if (r.org[a] < r.lo[a] || r.org[a] > r.hi[a]) begin
                        why = rbst_pkg::RSN_PAR_OUT;
                        break;
                    end
                    continue;
                end
                n = clamp_distance(((longint'(r.lo[a]) - longint'(r.org[a])) * 65536) / d);
                f = clamp_distance(((longint'(r.hi[a]) - longint'(r.org[a])) * 65536) / d);
                if (n > f) begin
                    tmp = n;
                    n = f;
                    f = tmp;
                end
                if (n > t_near) t_near = n;
                if (f < t_far) t_far = f;
                if (t_near > t_far) begin
                    why = rbst_pkg::RSN_DISJOINT;
                    break;
                end
            end
            if (why == rbst_pkg::RSN_HIT && t_far < 0) why = rbst_pkg::RSN_BEHIND;
        end
        res.hit = (why == rbst_pkg::RSN_HIT);
        res.reason = why;
        res.t_enter = res.hit ? 32'(t_near) : '0;
        res.t_exit = res.hit ? 32'(t_far) : '0;
        return res;
    endfunction

    class slab_scoreboard;
        slab_result_t pending [$];

        function void note_request(input ray_box_t r, input logic [15:0] thr);
            pending.push_back(clip_ray(r, thr));
        endfunction

        task check_result(input logic [63:0] data, input logic [3:0] user);
            slab_result_t e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %h/%h", user, data));
                return;
            end
            e = pending.pop_front();
            if (user[0] !== e.hit)
                report($sformatf("hit %b, expected %b", user[0], e.hit));
            if (user[3:1] !== e.reason)
                report($sformatf("reason %0d, expected %0d", user[3:1], e.reason));
            if (data[31:0] !== e.t_enter)
                report($sformatf("t_enter %h, expected %h", data[31:0], e.t_enter));
            if (data[63:32] !== e.t_exit)
                report($sformatf("t_exit %h, expected %h", data[63:32], e.t_exit));
        endtask
    endclass

    slab_scoreboard board = new();

    function automatic logic [IN_BITS-1:0] pack_request(input ray_box_t r);
        logic [IN_BITS-1:0] v;
        v = '0;
        for (int a = 0; a < 3; a++) begin
            v[32*a +: 32] = r.org[a];
            v[96 + 18*a +: 18] = r.dir[a];
            v[150 + 32*a +: 32] = r.lo[a];
            v[246 + 32*a +: 32] = r.hi[a];
        end
        return v;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
        endcase
    endfunction

    function automatic logic [17:0] rand_dir();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 18'($signed($urandom_range(0, 64)) - 32);
            2: return 18'($urandom);
            3: return $urandom_range(0, 1) ? 18'sd65536 : -18'sd65536;
            default: return 18'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic ray_box_t rand_request();
        ray_box_t r;
        logic [31:0] p, q;
        for (int a = 0; a < 3; a++) begin
            r.org[a] = rand_coord();
            r.dir[a] = rand_dir();
            p = rand_coord();
            q = rand_coord();
            if ($urandom_range(0, 19) != 0 && $signed(p) > $signed(q)) begin
                r.lo[a] = q;
                r.hi[a] = p;
            end else begin
                r.lo[a] = p;
                r.hi[a] = q;
            end
        end
        return r;
    endfunction

    function automatic ray_box_t make_request(input int ox, input int dx, input int lo,
                                              input int hi);
        ray_box_t r;
        for (int a = 0; a < 3; a++) begin
            r.org[a] = ox;
            r.dir[a] = 18'(dx);
            r.lo[a] = lo;
            r.hi[a] = hi;
        end
        return r;
    endfunction

    task automatic send_request(input ray_box_t r);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata <= pack_request(r);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_request(r, threshold);
        @(negedge aclk);
    endtask

    task automatic write_threshold(input logic [15:0] value);
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (45) @(negedge aclk);
        cfg_wdata <= value;
        cfg_we <= 1'b1;
        @(negedge aclk);
        cfg_we <= 1'b0;
        threshold = value;
    endtask

    always @(negedge aclk)
        m_tready <= ($urandom_range(0, 99) >= idle_pct);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge aclk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        ray_box_t r;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed requests: a hit, bad box, bad ray, parallel cases, behind, saturation and disjoint.
        r = make_request(0, 65536, -65536, 65536);
        send_request(r);
        r.lo[1] = 65537;
        send_request(r);
        send_request(make_request(0, 0, -65536, 65536));
        r = make_request(0, 0, -65536, 65536);
        r.dir[2] = 18'sd1;
        send_request(r);
        r = make_request(0, -65536, 65536, 131072);
        send_request(r);
        r = make_request(32'h8000_0000, 1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(r);
        r = make_request(32'h7FFF_FFFF, -1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(r);
        r = make_request(0, 18'h1FFFF, 10, 20);
        send_request(r);
        r = make_request(0, 18'h20000, -20, -10);
        send_request(r);
        r = make_request(0, 65536, 65536, 131072);
        r.lo[1] = -131072;
        r.hi[1] = -65536;
        send_request(r);
        r = make_request(0, 65536, 65536, 131072);
        r.dir[0] = 0;
        r.dir[1] = 0;
        r.dir[2] = 0;
        r.dir[1] = 18'sd65536;
        send_request(r);

        write_threshold(16'hFFFF);
        send_request(make_request(0, 65535, -65536, 65536));
        send_request(make_request(0, 65536, -65536, 65536));
        r = make_request(0, 100, -65536, 65536);
        r.org[2] = 131072;
        send_request(r);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_threshold('0);
                1: write_threshold(16'd32);
                2: write_threshold(16'($urandom));
                default: write_threshold(16'hFFFF);
            endcase
            idle_pct = (phase == 1) ? 0 : 19;
            for (int i = 0; i < 150; i++) send_request(rand_request());
        end

        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
